FILE: src/bmo_pkg.sv
// Shared types and constants for the 3x3 binary morphological opening block.
// No dependencies; every other file of the block imports this package.
package bmo_pkg;

   localparam int PIXEL_W      = 8;
   localparam int KERNEL_SIZE  = 3;
   localparam int KERNEL_TAPS  = KERNEL_SIZE * KERNEL_SIZE;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;

   typedef logic [PIXEL_W-1:0]     pixel_type;
   typedef logic [KERNEL_TAPS-1:0] mask_type;

   // Binary levels: erosion looks for the low level, dilation for the high one.
   localparam pixel_type LEVEL_LOW  = 8'd0;
   localparam pixel_type LEVEL_HIGH = 8'd255;

   // One pixel slot of the stream and the frame-end marker that travels with it.
   typedef struct packed {
      logic      last;
      pixel_type pixel;
   } beat_type;

   // A beat plus its valid flag, as handed from one cell to the next.
   typedef struct packed {
      logic     valid;
      beat_type beat;
   } tick_type;

endpackage

FILE: src/bmo_if.sv
// Channel interfaces of the opening block: pixel requests, results and register writes.
// Depends on bmo_pkg for the payload types and widths.

interface bmo_req_if;
   import bmo_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_in;
   logic      pad_tick;

   modport source (output valid, output pixel_in, output pad_tick, input ready);
   modport sink   (input valid, input pixel_in, input pad_tick, output ready);
endinterface

interface bmo_rsp_if;
   import bmo_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_out;
   logic      end_of_frame;

   modport source (output valid, output pixel_out, output end_of_frame, input ready);
   modport sink   (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

interface bmo_csr_if;
   import bmo_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/bmo_morph_cell.sv
// One 3x3 morphological cell: line memory, window and masked compare against a level.
// Depends on bmo_pkg; two of these in a chain form the opening.
module bmo_morph_cell #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   frame_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]  frame_height,
   input  bmo_pkg::mask_type                kernel_mask,
   input  bmo_pkg::pixel_type               level,
   input  bmo_pkg::tick_type                tick_in,
   output bmo_pkg::tick_type                tick_out
);
   import bmo_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 4);

   // Each line memory word holds the row above and the row two above a column.
   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_word_type;

   line_word_type   line_mem [MAX_WIDTH];
   line_word_type   rd_word_ff;
   line_word_type   wr_word;
   logic            wr_en;

   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;

   logic            a_valid_ff;
   beat_type        a_beat_ff;
   logic [RW-1:0]   a_row_ff;
   logic [CW-1:0]   a_col_ff;

   pixel_type       win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic            b_valid_ff;
   logic            b_last_ff;
   logic            b_rep_left_ff;
   logic            b_rep_right_ff;

   tick_type        c_tick_ff;

   pixel_type       new_col [KERNEL_SIZE];
   logic            rep_top, rep_bottom, fwd, rep_left, rep_right;
   pixel_type       view [KERNEL_SIZE][KERNEL_SIZE];
   logic            hit;
   pixel_type       result;

   // Position of the next tick within this cell's own stream.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (advance && tick_in.valid) begin
         if (tick_in.beat.last) begin
            row_in = '0;
            col_in = '0;
         end else if (WW'(col_ff) + WW'(1) == frame_width) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // The word read for the previous tick is shifted down and written back at its column.
   assign wr_en   = advance && a_valid_ff;
   assign wr_word = '{upper: a_beat_ff.pixel, lower: rd_word_ff.upper};

   // Line memory with a registered read; a write to the same column is passed straight on.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[a_col_ff] <= wr_word;
      end
      if (advance) begin
         if (wr_en && (a_col_ff == col_ff)) begin
            rd_word_ff <= wr_word;
         end else begin
            rd_word_ff <= line_mem[col_ff];
         end
      end
   end

   // Incoming column with rows replicated at the top and bottom edges of the frame.
   always_comb begin
      rep_top    = (a_row_ff == RW'(1));
      rep_bottom = (a_row_ff == RW'(frame_height));
      new_col[0] = rep_top ? rd_word_ff.upper : rd_word_ff.lower;
      new_col[1] = rd_word_ff.upper;
      new_col[2] = rep_bottom ? rd_word_ff.upper : a_beat_ff.pixel;
      fwd        = (a_row_ff >= RW'(2)) || ((a_row_ff == RW'(1)) && (a_col_ff != '0));
      rep_left   = (a_col_ff == CW'(1)) || (frame_width == WW'(1));
      rep_right  = (a_col_ff == '0);
   end

   // Window view with columns replicated at the left and right edges.
   always_comb begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         view[0][m] = b_rep_left_ff  ? win_ff[1][m] : win_ff[0][m];
         view[1][m] = win_ff[1][m];
         view[2][m] = b_rep_right_ff ? win_ff[1][m] : win_ff[2][m];
      end
   end

   // Masked compare: any selected neighbour at the level forces the level, else keep the centre.
   always_comb begin
      hit = 1'b0;
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         for (int n = 0; n < KERNEL_SIZE; n++) begin
            if (kernel_mask[KERNEL_SIZE * m + n] && (view[n][m] == level)) begin
               hit = 1'b1;
            end
         end
      end
      result = hit ? level : win_ff[1][1];
   end

   // Control state of the cell pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff          <= '0;
         col_ff          <= '0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_tick_ff.valid <= 1'b0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         if (advance) begin
            a_valid_ff      <= tick_in.valid;
            b_valid_ff      <= a_valid_ff && fwd;
            c_tick_ff.valid <= b_valid_ff;
         end
      end
   end

   // Payload of the cell pipeline and the window shift.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_beat_ff      <= tick_in.beat;
         a_row_ff       <= row_ff;
         a_col_ff       <= col_ff;
         b_last_ff      <= a_beat_ff.last;
         b_rep_left_ff  <= rep_left;
         b_rep_right_ff <= rep_right;
         c_tick_ff.beat <= '{last: b_last_ff, pixel: result};
         if (a_valid_ff) begin
            for (int m = 0; m < KERNEL_SIZE; m++) begin
               win_ff[0][m] <= win_ff[1][m];
               win_ff[1][m] <= win_ff[2][m];
               win_ff[2][m] <= new_col[m];
            end
         end
      end
   end

   assign tick_out = c_tick_ff;

endmodule

FILE: src/binary_morph_opening_3x3.sv
// Top level of the streaming 3x3 binary morphological opening.
// Depends on bmo_pkg, the channel interfaces in bmo_if and bmo_morph_cell.
//
// Usage: pixels enter in raster order on req_chan, one per transaction; a transaction
// with pad_tick set carries no pixel and is ignored while pixels of the frame are still
// due. After the W*H pixels of a frame the source sends 2*W+2 further transactions
// (pad or not) to drain the block. Each transaction from the (2*W+3)-th of the frame
// onwards yields one opened pixel on rsp_chan; end_of_frame marks the last of them.
// Registers are written on csr_chan (index 0 kernel mask, 1 width, 2 height) while the
// block is idle; a width or height write restarts the frame position.
// Throughput: one transaction per clock while the output buffer has a free entry, set by
// the line memory in each of the two cells, read and written once per transaction.
// A result passes the A, B and C registers of both cells after the transaction that
// causes it and is then written to the output buffer, which offers it on rsp_chan.
// A two-entry output buffer lets input be taken while one result waits; when the
// receiver stalls with both entries full, req_chan.ready drops and the chain holds.
// Reset sets the register defaults, the frame position and all valid flags; the line
// memories need no clearing, as only entries written in the current frame reach a result.
module binary_morph_opening_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input logic        clock,
   input logic        reset,
   bmo_req_if.sink    req_chan,
   bmo_rsp_if.source  rsp_chan,
   bmo_csr_if.sink    csr_chan
);
   import bmo_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 4);

   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MASK  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam mask_type              MASK_RESET   = 9'd511;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 11'd480;

   mask_type                kernel_mask_ff;
   logic [CSR_DATA_W-1:0]   image_width_ff;
   logic [CSR_DATA_W-1:0]   image_height_ff;
   logic                    restart;

   logic [WW-1:0]           eff_width;
   logic [HW-1:0]           eff_height;

   logic [RW-1:0]           row_ff, row_in;
   logic [CW-1:0]           col_ff, col_in;
   logic                    advance, accept, ignore, at_last;
   tick_type                in_tick, eroded_tick, opened_tick;

   logic [1:0]              out_count_ff, out_count_in;
   logic                    out_wr_ptr_ff, out_rd_ptr_ff;
   beat_type                out_beat_ff [2];
   logic                    push, pop;

   // Register writes are always taken.
   assign csr_chan.ready = 1'b1;
   assign restart = csr_chan.valid &&
                    ((csr_chan.index == CSR_IMAGE_WIDTH) || (csr_chan.index == CSR_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mask_ff  <= MASK_RESET;
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_KERNEL_MASK:  kernel_mask_ff  <= csr_chan.data[KERNEL_TAPS-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_chan.data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Frame size clamped to the supported range.
   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = WW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         eff_height = HW'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         eff_height = HW'(MAX_HEIGHT);
      end else begin
         eff_height = HW'(image_height_ff);
      end
   end

   // Input side: the chain moves whenever the output buffer has a free entry.
   assign advance        = (out_count_ff != 2'd2);
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;
   assign ignore         = req_chan.pad_tick && (row_ff < RW'(eff_height));

   // The last drain tick sits at raster position (H+2)*W+1.
   always_comb begin
      if (eff_width == WW'(1)) begin
         at_last = (row_ff == RW'(eff_height) + RW'(3)) && (col_ff == '0);
      end else begin
         at_last = (row_ff == RW'(eff_height) + RW'(2)) && (col_ff == CW'(1));
      end
   end

   assign in_tick.valid      = accept && !ignore;
   assign in_tick.beat.pixel = req_chan.pixel_in;
   assign in_tick.beat.last  = at_last;

   // Frame position of the next tick.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (in_tick.valid) begin
         if (at_last) begin
            row_in = '0;
            col_in = '0;
         end else if (WW'(col_ff) + WW'(1) == eff_width) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Erosion cell followed by dilation cell.
   bmo_morph_cell #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_erode (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .restart      (restart),
      .frame_width  (eff_width),
      .frame_height (eff_height),
      .kernel_mask  (kernel_mask_ff),
      .level        (LEVEL_LOW),
      .tick_in      (in_tick),
      .tick_out     (eroded_tick)
   );

   bmo_morph_cell #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dilate (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .restart      (restart),
      .frame_width  (eff_width),
      .frame_height (eff_height),
      .kernel_mask  (kernel_mask_ff),
      .level        (LEVEL_HIGH),
      .tick_in      (eroded_tick),
      .tick_out     (opened_tick)
   );

   // Two-entry output buffer between the chain and the result channel.
   assign push = advance && opened_tick.valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      out_count_in = out_count_ff;
      if (push && !pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (pop && !push) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff  <= 2'd0;
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
      end else begin
         out_count_ff <= out_count_in;
         if (push) begin
            out_wr_ptr_ff <= !out_wr_ptr_ff;
         end
         if (pop) begin
            out_rd_ptr_ff <= !out_rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_beat_ff[out_wr_ptr_ff] <= opened_tick.beat;
      end
   end

   assign rsp_chan.valid        = (out_count_ff != 2'd0);
   assign rsp_chan.pixel_out    = out_beat_ff[out_rd_ptr_ff].pixel;
   assign rsp_chan.end_of_frame = out_beat_ff[out_rd_ptr_ff].last;

   // The position returns to the origin after the last tick of a frame.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (in_tick.valid && at_last && !restart) |=> (row_ff == '0) && (col_ff == '0))
      else $error("frame position did not return to the origin after the last tick");

   // A pad transaction while pixels are due leaves the position untouched.
   a_pad_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && ignore && !restart) |=> ($stable(row_ff) && $stable(col_ff)))
      else $error("ignored pad transaction moved the frame position");

   // While the output buffer is full the result at the end of the chain holds.
   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      (opened_tick.valid && !advance) |=> $stable(opened_tick))
      else $error("result left the chain while the output buffer was full");

endmodule

FILE: dv/binary_morph_opening_3x3_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_morph_opening_3x3: random and directed frames are checked
// against an in-bench model of the 3x3 opening. Depends on bmo_pkg, bmo_if and the block itself.
module binary_morph_opening_3x3_tb;
   import bmo_pkg::*;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int RING_DEPTH     = 2 * MAX_WIDTH + 3;
   localparam int RANDOM_TICKS   = 1300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam mask_type FULL_MASK  = 9'b111_111_111;
   localparam mask_type CROSS_MASK = 9'b010_111_010;

   // Register indexes of the write channel.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KERNEL_MASK  = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2,
      REG_SPARE        = 2'd3
   } csr_reg_e;

   typedef struct packed {
      logic      pad;
      pixel_type pixel;
   } stream_tick_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmo_req_if req_chan ();
   bmo_rsp_if rsp_chan ();
   bmo_csr_if csr_chan ();

   binary_morph_opening_3x3 #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Model state: register copies, frame position and the two line rings.
   mask_type  kernel_mask_cfg;
   int        width_cfg;
   int        height_cfg;
   int        frame_row;
   int        frame_col;
   pixel_type input_ring  [RING_DEPTH];
   pixel_type eroded_ring [RING_DEPTH];

   stream_tick_t pixel_stream[$];
   beat_type     opened_pixels_due[$];

   int items_queued   = 0;
   int items_taken    = 0;
   int counted_ticks  = 0;
   int regs_written   = 0;
   int results_seen   = 0;
   int frames_seen    = 0;
   int error_count    = 0;
   int quiet_cycles   = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   logic [15:0] stall_pattern;
   int          pattern_age;

   function automatic int clamp_size(input int value, input int limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // One pass over the replicated-edge 3x3 window of raster pixel k. Erosion looks for the
   // low level in the input ring, dilation for the high level in the eroded ring; a masked
   // hit forces that level, otherwise the centre is kept.
   function automatic pixel_type morph_pixel(input bit dilate, input int k, input int w,
                                             input int h);
      pixel_type level;
      pixel_type centre;
      pixel_type p;
      bit        hit;
      int        r, c, rr, cc, idx;
      level  = dilate ? LEVEL_HIGH : LEVEL_LOW;
      r      = k / w;
      c      = k % w;
      hit    = 1'b0;
      centre = '0;
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         for (int n = 0; n < KERNEL_SIZE; n++) begin
            rr = r + m - 1;
            cc = c + n - 1;
            if (rr < 0) rr = 0;
            if (rr > h - 1) rr = h - 1;
            if (cc < 0) cc = 0;
            if (cc > w - 1) cc = w - 1;
            idx = (rr * w + cc) % RING_DEPTH;
            p   = dilate ? eroded_ring[idx] : input_ring[idx];
            if (m == 1 && n == 1) centre = p;
            if (kernel_mask_cfg[m * KERNEL_SIZE + n] && p == level) hit = 1'b1;
         end
      end
      return hit ? level : centre;
   endfunction

   // Advances the model by one accepted transaction; returns 1 when it yields an opened pixel.
   function automatic bit opening_step(input pixel_type value, input logic is_pad,
                                       output beat_type opened);
      int w, h, total, lag, last_tick, t;
      w         = clamp_size(width_cfg, MAX_WIDTH);
      h         = clamp_size(height_cfg, MAX_HEIGHT);
      total     = w * h;
      lag       = w + 1;
      last_tick = total + 2 * lag - 1;
      t         = frame_row * w + frame_col;
      opened    = '0;

      // A pad while pixels are still due is ignored altogether.
      if (t < total) begin
         if (is_pad) return 1'b0;
         input_ring[t % RING_DEPTH] = value;
      end
      if (t >= lag && t - lag < total)
         eroded_ring[(t - lag) % RING_DEPTH] = morph_pixel(1'b0, t - lag, w, h);
      if (t >= 2 * lag) begin
         opened.pixel = morph_pixel(1'b1, t - 2 * lag, w, h);
         opened.last  = (t == last_tick);
      end

      if (t >= last_tick) begin
         frame_row = 0;
         frame_col = 0;
      end else begin
         frame_col++;
         if (frame_col >= w) begin
            frame_col = 0;
            frame_row++;
         end
      end
      return t >= 2 * lag;
   endfunction

   // Mostly binary levels at a per-frame density, now and then a grey level.
   function automatic pixel_type pick_pixel(input int high_rate);
      if ($urandom_range(0, 9) == 0) return pixel_type'($urandom());
      return ($urandom_range(0, 99) < high_rate) ? LEVEL_HIGH : LEVEL_LOW;
   endfunction

   function automatic mask_type pick_mask();
      case ($urandom_range(0, 4))
         0: return FULL_MASK;
         1: return '0;
         2: return CROSS_MASK;
         3: return mask_type'(1 << $urandom_range(0, KERNEL_TAPS - 1));
         default: return mask_type'($urandom());
      endcase
   endfunction

   task automatic queue_tick(input pixel_type value, input logic is_pad);
      pixel_stream.push_back('{pad: is_pad, pixel: value});
      items_queued++;
   endtask

   // Waits until every transaction is taken and every opened pixel has come back,
   // then lets the pipeline empty of transactions that yield nothing.
   task automatic wait_idle();
      while (items_taken != items_queued || opened_pixels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: one transaction on the write channel, mirrored into the model.
   task automatic write_reg(input csr_reg_e idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_KERNEL_MASK: kernel_mask_cfg = value[KERNEL_TAPS-1:0];
         REG_IMAGE_WIDTH: begin
            width_cfg = int'(value);
            frame_row = 0;
            frame_col = 0;
         end
         REG_IMAGE_HEIGHT: begin
            height_cfg = int'(value);
            frame_row = 0;
            frame_col = 0;
         end
         default: ;
      endcase
      regs_written++;
   endtask

   // Queues one frame of w x h pixels and its drain. Ignored pads are sprinkled among the
   // pixels; drain ticks are pads or real pixels at random. stop_at cuts the frame short,
   // mask_at changes the mask part way through once the block has gone idle.
   task automatic queue_frame(input int w, input int h, input int stop_at, input int mask_at);
      int ticks;
      int high_rate;
      int pad_rate;
      ticks     = w * h + 2 * w + 2;
      high_rate = ($urandom_range(0, 2) == 0) ? 10 : (($urandom_range(0, 1) == 0) ? 50 : 90);
      pad_rate  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 15);
      for (int i = 0; i < ticks && i != stop_at; i++) begin
         if (i == mask_at) begin
            wait_idle();
            write_reg(REG_KERNEL_MASK, CSR_DATA_W'(pick_mask()));
         end
         if (i < w * h) begin
            while ($urandom_range(0, 99) < pad_rate) queue_tick(pixel_type'($urandom()), 1'b1);
            queue_tick(pick_pixel(high_rate), 1'b0);
         end else begin
            queue_tick(pick_pixel(high_rate), 1'(($urandom_range(0, 1))));
         end
         counted_ticks++;
      end
   endtask

   // Request driver: bursts of transactions separated by random gaps.
   always @(posedge clock) begin
      stream_tick_t next_tick;
      beat_type     opened;
      if (reset) begin
         req_chan.valid    <= 1'b0;
         req_chan.pixel_in <= '0;
         req_chan.pad_tick <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (opening_step(req_chan.pixel_in, req_chan.pad_tick, opened))
               opened_pixels_due.push_back(opened);
            items_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0 || pixel_stream.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_chan.valid <= 1'b0;
            end else begin
               next_tick = pixel_stream.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.pixel_in <= next_tick.pixel;
               req_chan.pad_tick <= next_tick.pad;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Result receiver: ready follows a rotating stall pattern, replaced now and then.
   // Bit 0 of every pattern is set, so no stall lasts a whole rotation of the pattern.
   always @(posedge clock) begin
      if (reset) begin
         stall_pattern  <= 16'hFFFF;
         pattern_age    <= 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
            pattern_age   <= $urandom_range(50, 300);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_age   <= pattern_age - 1;
         end
         rsp_chan.ready <= stall_pattern[0];
      end
   end

   // Result monitor: each opened pixel is checked against the oldest prediction.
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.end_of_frame) frames_seen++;
         if (opened_pixels_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Error: result %0d (pixel %0d, end_of_frame %0b) with none predicted",
                        results_seen, rsp_chan.pixel_out, rsp_chan.end_of_frame);
         end else begin
            want = opened_pixels_due.pop_front();
            if (want.pixel !== rsp_chan.pixel_out || want.last !== rsp_chan.end_of_frame) begin
               error_count++;
               if (error_count <= 10)
                  $display("Error: result %0d pixel exp %0d got %0d, end_of_frame exp %0b got %0b",
                           results_seen, want.pixel, rsp_chan.pixel_out,
                           want.last, rsp_chan.end_of_frame);
            end
         end
      end
   end

   // Watchdog: too long without any transaction on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d predictions outstanding",
                     quiet_cycles, opened_pixels_due.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Stimulus sequence.
   initial begin
      int w_val;
      int h_val;
      int w_eff;
      int h_eff;
      int frame_ticks;
      int frame_runs;
      bit need_sizes;

      req_chan.valid    = 1'b0;
      req_chan.pixel_in = '0;
      req_chan.pad_tick = 1'b0;
      rsp_chan.ready    = 1'b0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = '0;
      csr_chan.data     = '0;
      kernel_mask_cfg   = FULL_MASK;
      width_cfg         = 640;
      height_cfg        = 480;
      frame_row         = 0;
      frame_col         = 0;
      w_val             = 1;
      h_val             = 1;

      @(posedge clock);
      while (reset) @(posedge clock);

      // Directed: a 3x2 frame with both levels, grey values, an ignored pad and a mask
      // change part way through; the unused register index must change nothing.
      write_reg(REG_SPARE, '1);
      write_reg(REG_KERNEL_MASK, CSR_DATA_W'(FULL_MASK));
      write_reg(REG_IMAGE_WIDTH, 11'd3);
      write_reg(REG_IMAGE_HEIGHT, 11'd2);
      queue_tick(LEVEL_LOW, 1'b0);
      queue_tick(8'hA5, 1'b1);
      queue_tick(LEVEL_HIGH, 1'b0);
      queue_tick(8'd1, 1'b0);
      queue_tick(8'd128, 1'b0);
      queue_tick(8'd254, 1'b0);
      wait_idle();
      write_reg(REG_KERNEL_MASK, CSR_DATA_W'(CROSS_MASK));
      queue_tick(8'd127, 1'b0);
      for (int i = 0; i < 8; i++) queue_tick(LEVEL_HIGH, 1'(i));
      wait_idle();

      // Directed: zero width taken as one, empty mask passes pixels through, and a size
      // write in the middle of a frame restarts it.
      write_reg(REG_KERNEL_MASK, '0);
      write_reg(REG_IMAGE_WIDTH, 11'd0);
      write_reg(REG_IMAGE_HEIGHT, 11'd1);
      queue_tick(8'd173, 1'b0);
      queue_tick(LEVEL_LOW, 1'b1);
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, 11'd1);
      queue_tick(8'd90, 1'b0);
      queue_tick(LEVEL_HIGH, 1'b0);
      queue_tick(LEVEL_LOW, 1'b1);
      queue_tick(8'd33, 1'b0);
      queue_tick(LEVEL_LOW, 1'b1);
      wait_idle();

      // Size extremes: the widest row (width above range) and the tallest column
      // (height above range), one frame each.
      write_reg(REG_KERNEL_MASK, CSR_DATA_W'(FULL_MASK));
      write_reg(REG_IMAGE_WIDTH, 11'd2047);
      write_reg(REG_IMAGE_HEIGHT, 11'd1);
      queue_frame(MAX_WIDTH, 1, -1, -1);
      wait_idle();
      write_reg(REG_KERNEL_MASK, CSR_DATA_W'(CROSS_MASK));
      write_reg(REG_IMAGE_WIDTH, 11'd1);
      write_reg(REG_IMAGE_HEIGHT, 11'd2047);
      queue_frame(1, MAX_HEIGHT, -1, -1);

      // Random part: small frames, often back to back, with occasional cut-short frames
      // and mask changes in the middle of a frame.
      counted_ticks = 0;
      need_sizes    = 1'b1;
      while (counted_ticks < RANDOM_TICKS) begin
         wait_idle();
         if (need_sizes || $urandom_range(0, 1) == 1) begin
            w_val = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            h_val = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w_val));
            write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h_val));
            need_sizes = 1'b0;
         end
         if ($urandom_range(0, 2) == 0) write_reg(REG_KERNEL_MASK, CSR_DATA_W'(pick_mask()));
         w_eff       = clamp_size(width_cfg, MAX_WIDTH);
         h_eff       = clamp_size(height_cfg, MAX_HEIGHT);
         frame_ticks = w_eff * h_eff + 2 * w_eff + 2;
         frame_runs  = $urandom_range(1, 3);
         for (int f = 0; f < frame_runs && !need_sizes; f++) begin
            case ($urandom_range(0, 9))
               0: begin
                  queue_frame(w_eff, h_eff, $urandom_range(1, frame_ticks - 1), -1);
                  need_sizes = 1'b1;
               end
               1: queue_frame(w_eff, h_eff, -1, $urandom_range(1, frame_ticks - 1));
               default: queue_frame(w_eff, h_eff, -1, -1);
            endcase
         end
      end

      wait_idle();
      error_count += opened_pixels_due.size();
      $display("Summary: %0d transactions sent, %0d register writes, %0d opened pixels checked",
               items_taken, regs_written, results_seen);
      $display("Summary: %0d complete frames seen, %0d errors", frames_seen, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: binary_morph_opening_3x3.f
src/bmo_pkg.sv
src/bmo_if.sv
src/bmo_morph_cell.sv
src/binary_morph_opening_3x3.sv
dv/binary_morph_opening_3x3_tb.sv
